// ===== hdl/mask_extreme_point_finder_defines.svh =====
// Assertion macros used by the mask extreme point finder top level.
`ifndef MASK_EXTREME_POINT_FINDER_DEFINES_SVH
`define MASK_EXTREME_POINT_FINDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MEPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MEPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mepf_pkg.sv =====
// Package: widths, reset values, register indexes and shared types.
package mepf_pkg;

   localparam int unsigned CFG_W       = 12;
   localparam int unsigned PIX_W       = 8;
   localparam int unsigned COORD_W     = 11;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned DEF_MAX_DIM = 2048;

   localparam logic [CFG_W-1:0] RST_FRAME_COLUMNS = 12'd640;
   localparam logic [CFG_W-1:0] RST_FRAME_ROWS    = 12'd480;
   localparam logic [PIX_W-1:0] RST_FG_THRESHOLD  = 8'd127;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_COLUMNS = 2'd0,
      CSR_FRAME_ROWS    = 2'd1,
      CSR_FG_THRESHOLD  = 2'd2
   } csr_index_type;

   // Input stage to tracker: item present and its foreground flag.
   typedef struct packed {
      logic valid;
      logic fg;
   } pix_ctl_type;

   typedef struct packed {
      logic               found;
      logic [COORD_W-1:0] top_row;
      logic [COORD_W-1:0] top_col;
      logic [COORD_W-1:0] bottom_row;
      logic [COORD_W-1:0] bottom_col;
      logic [COORD_W-1:0] left_col;
      logic [COORD_W-1:0] left_row;
      logic [COORD_W-1:0] right_col;
      logic [COORD_W-1:0] right_row;
   } point_set_type;

endpackage

// ===== hdl/mepf_tracker.sv =====
// Raster position counters and the four extreme-point registers.
module mepf_tracker import mepf_pkg::*; #(
   parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  pix_ctl_type   ctl,
   input  logic [CFG_W-1:0] frame_columns,
   input  logic [CFG_W-1:0] frame_rows,
   output logic          done,
   output point_set_type result
);

   localparam int unsigned CW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;

   logic [CW-1:0] cols_m1;
   logic [CW-1:0] rows_m1;

   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic          seen_ff, seen_in;
   logic [CW-1:0] top_row_ff, top_row_in, top_col_ff, top_col_in;
   logic [CW-1:0] bot_row_ff, bot_row_in, bot_col_ff, bot_col_in;
   logic [CW-1:0] left_row_ff, left_row_in, left_col_ff, left_col_in;
   logic [CW-1:0] right_row_ff, right_row_in, right_col_ff, right_col_in;

   logic fg;
   logic upd_top, upd_bot, upd_left, upd_right;
   logic row_end;

   // Size zero acts as one, above MAX_DIM acts as MAX_DIM.
   always_comb begin
      if (frame_columns == '0) begin
         cols_m1 = '0;
      end else if (32'(frame_columns) > MAX_DIM) begin
         cols_m1 = CW'(MAX_DIM - 1);
      end else begin
         cols_m1 = CW'(frame_columns - 1'b1);
      end
      if (frame_rows == '0) begin
         rows_m1 = '0;
      end else if (32'(frame_rows) > MAX_DIM) begin
         rows_m1 = CW'(MAX_DIM - 1);
      end else begin
         rows_m1 = CW'(frame_rows - 1'b1);
      end
   end

   assign fg        = ctl.valid & ctl.fg;
   assign upd_top   = fg & (~seen_ff | (row_ff <  top_row_ff));
   assign upd_bot   = fg & (~seen_ff | (row_ff >= bot_row_ff));
   assign upd_left  = fg & (~seen_ff | (col_ff <  left_col_ff));
   assign upd_right = fg & (~seen_ff | (col_ff >= right_col_ff));

   assign row_end = (col_ff >= cols_m1);
   assign done    = ctl.valid & row_end & (row_ff >= rows_m1);

   always_comb begin
      seen_in      = seen_ff | fg;
      top_row_in   = upd_top   ? row_ff : top_row_ff;
      top_col_in   = upd_top   ? col_ff : top_col_ff;
      bot_row_in   = upd_bot   ? row_ff : bot_row_ff;
      bot_col_in   = upd_bot   ? col_ff : bot_col_ff;
      left_row_in  = upd_left  ? row_ff : left_row_ff;
      left_col_in  = upd_left  ? col_ff : left_col_ff;
      right_row_in = upd_right ? row_ff : right_row_ff;
      right_col_in = upd_right ? col_ff : right_col_ff;
      if (row_end) begin
         col_in = '0;
         row_in = CW'(row_ff + 1'b1);
      end else begin
         col_in = CW'(col_ff + 1'b1);
         row_in = row_ff;
      end
   end

   // Result reflects the final pixel of the frame.
   always_comb begin
      result.found      = seen_in;
      result.top_row    = COORD_W'(top_row_in);
      result.top_col    = COORD_W'(top_col_in);
      result.bottom_row = COORD_W'(bot_row_in);
      result.bottom_col = COORD_W'(bot_col_in);
      result.left_col   = COORD_W'(left_col_in);
      result.left_row   = COORD_W'(left_row_in);
      result.right_col  = COORD_W'(right_col_in);
      result.right_row  = COORD_W'(right_row_in);
   end

   always_ff @(posedge clock) begin
      if (reset || (step && done)) begin
         row_ff       <= '0;
         col_ff       <= '0;
         seen_ff      <= 1'b0;
         top_row_ff   <= '0;
         top_col_ff   <= '0;
         bot_row_ff   <= '0;
         bot_col_ff   <= '0;
         left_row_ff  <= '0;
         left_col_ff  <= '0;
         right_row_ff <= '0;
         right_col_ff <= '0;
      end else if (step) begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         seen_ff      <= seen_in;
         top_row_ff   <= top_row_in;
         top_col_ff   <= top_col_in;
         bot_row_ff   <= bot_row_in;
         bot_col_ff   <= bot_col_in;
         left_row_ff  <= left_row_in;
         left_col_ff  <= left_col_in;
         right_row_ff <= right_row_in;
         right_col_ff <= right_col_in;
      end
   end

endmodule

// ===== hdl/mask_extreme_point_finder.sv =====
// Top level: mask extreme point finder.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_pixel
//   rsp       out        rsp_valid/rsp_stall   rsp_found and eight coordinates
//   csr       in         csr_we                csr_index, csr_wdata
//
// One pixel is taken every cycle unless req_stall is high; the tracker register update is the only loop.
// rsp_valid is registered: the frame's last pixel passes the input stage, then sets rsp_valid_ff as it steps.
// Reset clears counters, points and handshake state and restores register defaults.
// rsp_stall holds the result; req_stall rises only when the input stage is also full.
`include "mask_extreme_point_finder_defines.svh"

module mask_extreme_point_finder import mepf_pkg::*; #(
   parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIX_W-1:0]     req_pixel,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic [COORD_W-1:0]   rsp_top_row,
   output logic [COORD_W-1:0]   rsp_top_col,
   output logic [COORD_W-1:0]   rsp_bottom_row,
   output logic [COORD_W-1:0]   rsp_bottom_col,
   output logic [COORD_W-1:0]   rsp_left_col,
   output logic [COORD_W-1:0]   rsp_left_row,
   output logic [COORD_W-1:0]   rsp_right_col,
   output logic [COORD_W-1:0]   rsp_right_row,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   logic [CFG_W-1:0] frame_columns_ff;
   logic [CFG_W-1:0] frame_rows_ff;
   logic [PIX_W-1:0] fg_threshold_ff;

   pix_ctl_type   ctl_ff, ctl_in;
   point_set_type rsp_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   point_set_type result;
   logic          done;
   logic          advance;
   logic          step;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_columns_ff <= RST_FRAME_COLUMNS;
         frame_rows_ff    <= RST_FRAME_ROWS;
         fg_threshold_ff  <= RST_FG_THRESHOLD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_COLUMNS: frame_columns_ff <= csr_wdata;
            CSR_FRAME_ROWS:    frame_rows_ff    <= csr_wdata;
            CSR_FG_THRESHOLD:  fg_threshold_ff  <= csr_wdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // Output register frees up when empty or taken this cycle.
   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign step      = ctl_ff.valid & advance;
   assign req_stall = ctl_ff.valid & ~advance;

   always_comb begin
      ctl_in = ctl_ff;
      if (!req_stall) begin
         ctl_in.valid = req_valid;
         ctl_in.fg    = (req_pixel >= fg_threshold_ff);
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step & done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && done) begin
         rsp_ff <= result;
      end
   end

   mepf_tracker #(
      .MAX_DIM (MAX_DIM)
   ) u_tracker (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .ctl           (ctl_ff),
      .frame_columns (frame_columns_ff),
      .frame_rows    (frame_rows_ff),
      .done          (done),
      .result        (result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_ff.found;
   assign rsp_top_row    = rsp_ff.top_row;
   assign rsp_top_col    = rsp_ff.top_col;
   assign rsp_bottom_row = rsp_ff.bottom_row;
   assign rsp_bottom_col = rsp_ff.bottom_col;
   assign rsp_left_col   = rsp_ff.left_col;
   assign rsp_left_row   = rsp_ff.left_row;
   assign rsp_right_col  = rsp_ff.right_col;
   assign rsp_right_row  = rsp_ff.right_row;

   `MEPF_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall,
      ctl_ff.valid && rsp_valid_ff && rsp_stall, "input stalled without backpressure")
   `MEPF_ASSERT_NOW(a_result_from_step, clock, reset, $rose(rsp_valid_ff),
      $past(ctl_ff.valid), "result appeared with no item in the tracker")
   `MEPF_ASSERT_NOW(a_empty_frame_zero, clock, reset, rsp_valid_ff && !rsp_ff.found,
      rsp_ff.top_row == '0 && rsp_ff.bottom_row == '0 && rsp_ff.left_col == '0 &&
      rsp_ff.right_col == '0 && rsp_ff.top_col == '0 && rsp_ff.right_row == '0,
      "empty frame result has nonzero coordinates")

endmodule

// ===== tb/tb_mask_extreme_point_finder.sv =====
// Self-checking testbench for the mask extreme point finder: directed frames, random phases.
module tb_mask_extreme_point_finder;
   import mepf_pkg::*;

   localparam int unsigned IDLE_MAX      = 19;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned RANDOM_PIXELS = 530;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;

   // Predicts the point set of each frame and checks the block's results against it.
   class extreme_point_tracker;
      typedef struct {
         int unsigned row;
         int unsigned col;
      } coord_pair;

      logic [CFG_W-1:0] columns_reg;
      logic [CFG_W-1:0] rows_reg;
      logic [PIX_W-1:0] threshold_reg;
      int unsigned      row_pos;
      int unsigned      col_pos;
      bit               seen_fg;
      coord_pair        top;
      coord_pair        bottom;
      coord_pair        left;
      coord_pair        right;
      point_set_type    expected_points[$];
      int unsigned      error_count;
      int unsigned      frames_predicted;
      int unsigned      frames_checked;

      function new();
         columns_reg      = RST_FRAME_COLUMNS;
         rows_reg         = RST_FRAME_ROWS;
         threshold_reg    = RST_FG_THRESHOLD;
         error_count      = 0;
         frames_predicted = 0;
         frames_checked   = 0;
         start_frame();
      endfunction

      function void start_frame();
         row_pos = 0;
         col_pos = 0;
         seen_fg = 1'b0;
         top     = '{0, 0};
         bottom  = '{0, 0};
         left    = '{0, 0};
         right   = '{0, 0};
      endfunction

      function void write_reg(csr_index_type idx, logic [CFG_W-1:0] value);
         case (idx)
            CSR_FRAME_COLUMNS: columns_reg = value;
            CSR_FRAME_ROWS:    rows_reg = value;
            CSR_FG_THRESHOLD:  threshold_reg = value[PIX_W-1:0];
            default: ;
         endcase
      endfunction

      // Zero acts as one, anything past the maximum acts as the maximum.
      function int unsigned clamp_dim(logic [CFG_W-1:0] value);
         if (value == 0) return 1;
         if (value > DEF_MAX_DIM) return DEF_MAX_DIM;
         return value;
      endfunction

      function void take_pixel(logic [PIX_W-1:0] px);
         coord_pair     here;
         int unsigned   cols;
         int unsigned   rows;
         bit            row_end;
         point_set_type pts;
         cols = clamp_dim(columns_reg);
         rows = clamp_dim(rows_reg);
         here = '{row_pos, col_pos};
         if (px >= threshold_reg) begin
            if (!seen_fg) begin
               top     = here;
               bottom  = here;
               left    = here;
               right   = here;
               seen_fg = 1'b1;
            end else begin
               if (here.row < top.row) top = here;
               if (here.row >= bottom.row) bottom = here;
               if (here.col < left.col) left = here;
               if (here.col >= right.col) right = here;
            end
         end
         // Counters already past a shrunken size end the row or frame at once.
         row_end = (col_pos >= cols - 1);
         if (row_end && row_pos >= rows - 1) begin
            pts.found      = seen_fg;
            pts.top_row    = COORD_W'(top.row);
            pts.top_col    = COORD_W'(top.col);
            pts.bottom_row = COORD_W'(bottom.row);
            pts.bottom_col = COORD_W'(bottom.col);
            pts.left_col   = COORD_W'(left.col);
            pts.left_row   = COORD_W'(left.row);
            pts.right_col  = COORD_W'(right.col);
            pts.right_row  = COORD_W'(right.row);
            expected_points = {expected_points, pts};
            frames_predicted++;
            start_frame();
         end else if (row_end) begin
            col_pos = 0;
            row_pos++;
         end else begin
            col_pos++;
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
         end
      endfunction

      function void check_points(point_set_type got);
         point_set_type want;
         if (expected_points.size() == 0) begin
            $error("result with no frame pending: found=%0d", got.found);
            error_count++;
            return;
         end
         want = expected_points.pop_front();
         frames_checked++;
         compare_field("found", want.found, got.found);
         compare_field("top_row", want.top_row, got.top_row);
         compare_field("top_col", want.top_col, got.top_col);
         compare_field("bottom_row", want.bottom_row, got.bottom_row);
         compare_field("bottom_col", want.bottom_col, got.bottom_col);
         compare_field("left_col", want.left_col, got.left_col);
         compare_field("left_row", want.left_row, got.left_row);
         compare_field("right_col", want.right_col, got.right_col);
         compare_field("right_row", want.right_row, got.right_row);
      endfunction

      function int unsigned pending();
         return expected_points.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [PIX_W-1:0]     req_pixel;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_found;
   logic [COORD_W-1:0]   rsp_top_row;
   logic [COORD_W-1:0]   rsp_top_col;
   logic [COORD_W-1:0]   rsp_bottom_row;
   logic [COORD_W-1:0]   rsp_bottom_col;
   logic [COORD_W-1:0]   rsp_left_col;
   logic [COORD_W-1:0]   rsp_left_row;
   logic [COORD_W-1:0]   rsp_right_col;
   logic [COORD_W-1:0]   rsp_right_row;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   extreme_point_tracker tracker;
   bit                   send_tight;
   bit                   recv_tight;
   bit                   hold_request;
   int unsigned          pixels_sent;
   int unsigned          settings_used;

   mask_extreme_point_finder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_top_row    (rsp_top_row),
      .rsp_top_col    (rsp_top_col),
      .rsp_bottom_row (rsp_bottom_row),
      .rsp_bottom_col (rsp_bottom_col),
      .rsp_left_col   (rsp_left_col),
      .rsp_left_row   (rsp_left_row),
      .rsp_right_col  (rsp_right_col),
      .rsp_right_row  (rsp_right_row),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned draw_idle(bit tight);
      return tight ? 0 : $urandom_range(IDLE_MAX, 0);
   endfunction

   // Mostly pixels on the chosen side of the threshold, with some noise.
   function automatic logic [PIX_W-1:0] make_pixel(int unsigned density, logic [PIX_W-1:0] thr);
      if ($urandom_range(9, 0) == 0) return PIX_W'($urandom_range(255, 0));
      if ($urandom_range(99, 0) < density) return PIX_W'($urandom_range(255, thr));
      if (thr == 0) return '0;
      return PIX_W'($urandom_range(thr - 1, 0));
   endfunction

   function automatic int unsigned pick_dim(int unsigned common_max, int unsigned rare_max);
      case ($urandom_range(9, 0))
         0: return 0;
         1: return $urandom_range(rare_max, common_max + 1);
         default: return $urandom_range(common_max, 1);
      endcase
   endfunction

   task automatic send_pixel(logic [PIX_W-1:0] px);
      int unsigned gap;
      gap = draw_idle(send_tight);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
      tracker.take_pixel(px);
      pixels_sent++;
   endtask

   task automatic put_reg(csr_index_type idx, logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_reg(idx, value);
   endtask

   // A negative threshold leaves that register as it is.
   task automatic configure(int unsigned cols, int unsigned rows, int thr);
      put_reg(CSR_FRAME_COLUMNS, CFG_W'(cols));
      put_reg(CSR_FRAME_ROWS, CFG_W'(rows));
      if (thr >= 0) put_reg(CSR_FG_THRESHOLD, CFG_W'(thr));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Hold off the sender until every frame result is back and the pipeline is quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned  gap;
      point_set_type got;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = draw_idle(recv_tight);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got = '{found: rsp_found,
                 top_row: rsp_top_row, top_col: rsp_top_col,
                 bottom_row: rsp_bottom_row, bottom_col: rsp_bottom_col,
                 left_col: rsp_left_col, left_row: rsp_left_row,
                 right_col: rsp_right_col, right_row: rsp_right_row};
         tracker.check_points(got);
      end
   end

   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      logic [PIX_W-1:0] corner_frame [12];
      int unsigned      cols;
      int unsigned      rows;
      int               thr;
      int unsigned      density;
      int unsigned      frame_size;
      int unsigned      count;
      int unsigned      random_start;

      tracker   = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_pixel <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_FRAME_COLUMNS;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 4x3 frame at the reset threshold: values just below and at it, ties on the top and bottom edges.
      corner_frame = '{8'd0, 8'd126, 8'd0, 8'd0,
                       8'd0, 8'd127, 8'd255, 8'd0,
                       8'd200, 8'd0, 8'd0, 8'd128};
      configure(4, 3, -1);
      foreach (corner_frame[i]) send_pixel(corner_frame[i]);
      drain();

      // Size zero acts as one: a found frame, then an empty one.
      configure(0, 0, 255);
      send_pixel(8'd255);
      send_pixel(8'd254);
      drain();

      // Threshold zero: every pixel is foreground.
      configure(3, 2, 0);
      repeat (6) send_pixel(8'd0);
      drain();

      // Shrink the frame while counters sit past the new size.
      configure(4, 4, 127);
      send_pixel(8'd0);
      send_pixel(8'd200);
      repeat (4) send_pixel(8'd0);
      drain();
      configure(2, 1, -1);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd130);
      drain();

      // One-pixel frames while the receiver holds off: the block must back up.
      configure(1, 1, 128);
      send_tight   = 1'b1;
      hold_request = 1'b1;
      repeat (60) send_pixel(make_pixel(50, tracker.threshold_reg));
      drain();
      send_tight = 1'b0;

      random_start = pixels_sent;
      while (pixels_sent - random_start < RANDOM_PIXELS) begin
         cols = pick_dim(12, 40);
         rows = pick_dim(6, 12);
         case ($urandom_range(9, 0))
            0: thr = 0;
            1: thr = 255;
            2: thr = -1;
            default: thr = $urandom_range(255, 0);
         endcase
         configure(cols, rows, thr);
         send_tight = ($urandom_range(3, 0) == 0);
         recv_tight = ($urandom_range(3, 0) == 0);
         density    = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(60, 1);
         frame_size = tracker.clamp_dim(CFG_W'(cols)) * tracker.clamp_dim(CFG_W'(rows));
         count      = frame_size * $urandom_range(3, 1);
         // Sometimes stop mid-frame so the next setting lands inside a frame.
         if ($urandom_range(3, 0) == 0) count += $urandom_range(frame_size, 1);
         // Stay within the pixel budget of this phase.
         if (count > RANDOM_PIXELS - (pixels_sent - random_start))
            count = RANDOM_PIXELS - (pixels_sent - random_start);
         repeat (count) send_pixel(make_pixel(density, tracker.threshold_reg));
         drain();
      end

      // Sizes past the maximum act as the maximum: no row or frame ends early.
      send_tight = 1'b0;
      recv_tight = 1'b0;
      configure(4095, 1, -1);
      repeat (40) send_pixel(make_pixel(20, tracker.threshold_reg));
      drain();
      configure(1, 1, -1);
      send_pixel(make_pixel(20, tracker.threshold_reg));
      drain();
      configure(1, 4095, -1);
      repeat (40) send_pixel(make_pixel(20, tracker.threshold_reg));
      drain();
      configure(1, 1, -1);
      send_pixel(make_pixel(20, tracker.threshold_reg));
      drain();

      $display("Checked %0d of %0d predicted frames from %0d pixels over %0d settings.",
               tracker.frames_checked, tracker.frames_predicted, pixels_sent, settings_used);
      $display("Included sizes 0 to 4095, thresholds 0 and 255, mid-frame shrink, output hold.");
      if (tracker.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mepf_pkg.sv
hdl/mepf_tracker.sv
hdl/mask_extreme_point_finder.sv
tb/tb_mask_extreme_point_finder.sv
